// ===== src/asb_pkg.sv =====
package asb_pkg;

    // Default configuration of the bank.
    localparam int ASB_OSCILLATORS     = 16;
    localparam int ASB_SINE_TABLE_BITS = 10;
    localparam int ASB_MAX_BURST       = 64;

    // Quarter turn in Q30 and the output full scale (0x7FFF - 1).
    localparam logic [63:0] ASB_HALF_PI_Q30 = 64'd1686629713;
    localparam logic [15:0] ASB_OUT_SCALE   = 16'd32766;

    // Command codes of an input item.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BURST = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // One oscillator entry as held in a cell of the chain.
    typedef struct packed {
        logic [15:0] weight;
        logic [15:0] offset;
        logic [31:0] step;
        logic [31:0] phase;
    } t_osc_entry;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic shift;
        logic clr_time;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_ROT,
        S_DRAIN
    } t_seq_state;

    typedef enum logic [2:0] {
        D_IDLE,
        D_PREP,
        D_OVF,
        D_RUN,
        D_OUT
    } t_div_state;

    // Width of the signed weighted sum.
    function automatic int f_acc_w(input int osc);
        return 32 + $clog2(osc);
    endfunction

    // Width of the sum of the weights.
    function automatic int f_ws_w(input int osc);
        return 16 + $clog2(osc);
    endfunction

    // Quarter-wave sine entry k at the scale 1.0 = 32768, Taylor series in Q30.
    function automatic logic [16:0] f_quarter_sine(input int unsigned k,
                                                   input int unsigned tbits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic [63:0]        r;
        x    = (64'(k) * ASB_HALF_PI_Q30) >> (tbits - 2);
        term = x;
        s    = $signed(x);
        for (int m = 1; m <= 6; m++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (m)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((m % 2) == 1) begin
                s = s - $signed(term);
            end else begin
                s = s + $signed(term);
            end
        end
        if (s < 64'sd0) begin
            s = 64'sd0;
        end
        if (s > 64'sd1073741824) begin
            s = 64'sd1073741824;
        end
        r = ($unsigned(s) + 64'd16384) >> 15;
        return r[16:0];
    endfunction

endpackage

// ===== src/asb_cell.sv =====
module asb_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asb_pkg::t_cell_ctl  i_ctl,
    input  logic                i_wr_en,
    input  asb_pkg::t_osc_entry i_wr_entry,
    input  asb_pkg::t_osc_entry i_next_entry,
    output asb_pkg::t_osc_entry o_entry
);
    import asb_pkg::*;

    t_osc_entry r_entry;
    t_osc_entry n_entry;

    // A write wins; a time base reset rewinds the phase to the offset.
    always_comb begin
        n_entry = r_entry;
        if (i_wr_en) begin
            n_entry = i_wr_entry;
        end else if (i_ctl.clr_time) begin
            n_entry.phase = {r_entry.offset, 16'b0};
        end else if (i_ctl.shift) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== src/asb_div.sv =====
module asb_div #(
    parameter int OSCILLATORS = asb_pkg::ASB_OSCILLATORS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic signed [asb_pkg::f_acc_w(OSCILLATORS)-1:0] i_acc,
    input  logic [asb_pkg::f_ws_w(OSCILLATORS)-1:0]        i_wsum,
    input  logic                                           i_last,
    output logic                                           o_idle,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic signed [15:0]                             o_sample,
    output logic                                           o_last
);
    import asb_pkg::*;

    localparam int ACC_W = f_acc_w(OSCILLATORS);
    localparam int MAG_W = ACC_W - 1;
    localparam int WS_W  = f_ws_w(OSCILLATORS);
    localparam int CW    = WS_W + 16;

    t_div_state       r_state;
    t_div_state       n_state;
    logic [MAG_W-1:0] r_mag;
    logic [WS_W-1:0]  r_w;
    logic             r_neg;
    logic             r_zero;
    logic             r_last;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_div;
    logic [15:0]      r_q;
    logic [3:0]       r_step;
    logic [ACC_W-1:0] acc_abs;
    logic [MAG_W+14:0] scaled;
    logic             ovf;
    logic             fits;
    logic [15:0]      q_clip;

    assign acc_abs = i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
    // mag * 32766 / 32768 as a shift and subtract, floored.
    assign scaled  = {r_mag, 15'b0} - {14'b0, r_mag, 1'b0};
    assign ovf     = (r_rem >= {r_w, 16'b0});
    assign fits    = (r_rem >= r_div);

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_state = D_PREP;
                end
            end
            D_PREP: n_state = D_OVF;
            D_OVF: begin
                if (r_zero || ovf) begin
                    n_state = D_OUT;
                end else begin
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                if (r_step == 4'd15) begin
                    n_state = D_OUT;
                end
            end
            D_OUT: begin
                if (i_ready) begin
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_mag  <= acc_abs[MAG_W-1:0];
                    r_w    <= i_wsum;
                    r_neg  <= i_acc[ACC_W-1];
                    r_zero <= (i_wsum == '0);
                    r_last <= i_last;
                end
            end
            D_PREP: r_rem <= CW'(scaled[MAG_W+14:15]);
            D_OVF: begin
                r_q    <= (!r_zero && ovf) ? '1 : '0;
                r_div  <= CW'({r_w, 15'b0});
                r_step <= '0;
            end
            D_RUN: begin
                if (fits) begin
                    r_rem <= r_rem - r_div;
                end
                r_q    <= {r_q[14:0], fits};
                r_div  <= r_div >> 1;
                r_step <= r_step + 4'd1;
            end
            default: begin
            end
        endcase
    end

    assign q_clip   = (r_q > ASB_OUT_SCALE) ? ASB_OUT_SCALE : r_q;
    assign o_sample = $signed(r_neg ? (16'd0 - q_clip) : q_clip);
    assign o_last   = r_last;
    assign o_valid  = (r_state == D_OUT);
    assign o_idle   = (r_state == D_IDLE);

endmodule

// ===== src/additive_sine_bank_synth_unit.sv =====
// The first sample of a burst is offered after the command transfer, once the cell chain has made
// one rotation, the pipeline has drained, the sample has been handed off and the divider has run.
// Samples are paced by the chain rotating its entries past the single sine ROM and multiplier,
// and by the one-bit-per-cycle divider, which works on one sample while the chain evaluates the next.
// Command transfers are taken only when idle; an entry write then passes through a write state.
// Reset (synchronous, active low) clears all oscillator entries, the sample counter and control state.
module additive_sine_bank_synth_unit #(
    parameter int OSCILLATORS     = asb_pkg::ASB_OSCILLATORS,
    parameter int SINE_TABLE_BITS = asb_pkg::ASB_SINE_TABLE_BITS,
    parameter int MAX_BURST       = asb_pkg::ASB_MAX_BURST
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_osc_index,
    input  logic [15:0]        i_weight,
    input  logic [15:0]        i_phase_offset,
    input  logic [31:0]        i_freq_step,
    input  logic [6:0]         i_burst_len,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    output logic               o_last
);
    import asb_pkg::*;

    localparam int ROT_W  = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1;
    localparam int LEFT_W = $clog2(MAX_BURST + 1);
    localparam int ACC_W  = f_acc_w(OSCILLATORS);
    localparam int WS_W   = f_ws_w(OSCILLATORS);
    localparam int QN     = 1 << (SINE_TABLE_BITS - 2);
    localparam int AW     = SINE_TABLE_BITS - 1;

    // The quarter-wave table is built at elaboration and read as a ROM
    // with a registered output; the other quadrants come from symmetry.
    typedef logic [16:0] t_qtab [QN+1];

    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        for (int k = 0; k <= QN; k++) begin
            tab[k] = f_quarter_sine(32'(k), 32'(SINE_TABLE_BITS));
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = f_build_qtab();

    // Sequencer state and counters.
    t_seq_state        r_state;
    t_seq_state        n_state;
    logic [31:0]       r_count;
    logic [LEFT_W-1:0] r_left;
    logic [ROT_W-1:0]  r_rot;
    logic              in_acc;
    logic [6:0]        burst_len;

    // Pending entry write; the phase is computed from the current sample count.
    logic [3:0]        r_wr_idx;
    logic [15:0]       r_wr_weight;
    logic [15:0]       r_wr_off;
    logic [31:0]       r_wr_step;
    logic [31:0]       wr_prod;
    t_osc_entry        wr_entry;

    // The chain of cells. Cell 0 is the head, seen by the evaluation
    // pipeline; the last cell takes the head's entry with its phase advanced
    // by one sample, so a full rotation leaves every entry in place.
    t_osc_entry        cell_q [OSCILLATORS];
    t_osc_entry        cell_d [OSCILLATORS];
    t_osc_entry        head_adv;
    logic [OSCILLATORS-1:0] wr_sel;
    t_cell_ctl         cell_ctl;

    // Evaluation pipeline: ROM read, weight product, accumulation.
    logic [SINE_TABLE_BITS-1:0] tab_idx;
    logic [1:0]        quad;
    logic [AW-1:0]     rom_addr;
    logic              r_v1;
    logic              r_v2;
    logic [16:0]       r_sine;
    logic              r_n1;
    logic [15:0]       r_w1;
    logic [32:0]       prod_full;
    logic [30:0]       r_prod;
    logic              r_n2;
    logic [15:0]       r_w2;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] r_acc;
    logic [WS_W-1:0]   r_wsum;

    // Divider handoff.
    logic              div_start;
    logic              div_idle;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign burst_len = (i_burst_len > 7'(MAX_BURST)) ? 7'(MAX_BURST) : i_burst_len;

    // Next state and the controls that leave the sequencer. A sample is
    // handed to the divider once the pipeline has drained and the divider
    // has delivered its previous result.
    always_comb begin
        n_state            = r_state;
        cell_ctl.shift     = (r_state == S_ROT);
        cell_ctl.clr_time  = 1'b0;
        div_start          = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_WRITE: begin
                            if (7'(i_osc_index) < 7'(OSCILLATORS)) begin
                                n_state = S_WRITE;
                            end
                        end
                        CMD_BURST: begin
                            if (burst_len != 7'd0) begin
                                n_state = S_ROT;
                            end
                        end
                        CMD_CLEAR: cell_ctl.clr_time = 1'b1;
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_ROT: begin
                if (r_rot == ROT_W'(OSCILLATORS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && div_idle) begin
                    div_start = 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ROT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters, pipeline valids and the running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_rot   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_acc   <= '0;
            r_wsum  <= '0;
        end else begin
            if (cell_ctl.clr_time) begin
                r_count <= '0;
            end else if (div_start) begin
                r_count <= r_count + 32'd1;
            end

            if (in_acc) begin
                r_left <= LEFT_W'(burst_len);
            end else if (div_start) begin
                r_left <= r_left - LEFT_W'(1);
            end

            if (r_state == S_ROT) begin
                r_rot <= r_rot + ROT_W'(1);
            end else begin
                r_rot <= '0;
            end

            r_v1 <= (r_state == S_ROT);
            r_v2 <= r_v1;

            if (div_start) begin
                r_acc  <= '0;
                r_wsum <= '0;
            end else if (r_v2) begin
                r_acc  <= r_acc + (r_n2 ? -prod_ext : prod_ext);
                r_wsum <= r_wsum + WS_W'(r_w2);
            end
        end
    end

    // Entry write: the stored phase is step * count + offset, so that it
    // agrees with entries that have been advancing since the last rewind.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wr_idx    <= i_osc_index;
            r_wr_weight <= i_weight;
            r_wr_off    <= i_phase_offset;
            r_wr_step   <= i_freq_step;
        end
    end

    assign wr_prod = r_wr_step * r_count;

    always_comb begin
        wr_entry.weight = r_wr_weight;
        wr_entry.offset = r_wr_off;
        wr_entry.step   = r_wr_step;
        wr_entry.phase  = wr_prod + {r_wr_off, 16'b0};
    end

    always_comb begin
        head_adv       = cell_q[0];
        head_adv.phase = cell_q[0].phase + cell_q[0].step;
    end

    for (genvar j = 0; j < OSCILLATORS; j++) begin : g_cell
        if (j == OSCILLATORS - 1) begin : g_tail
            assign cell_d[j] = head_adv;
        end else begin : g_link
            assign cell_d[j] = cell_q[j+1];
        end

        assign wr_sel[j] = (r_state == S_WRITE) && (7'(r_wr_idx) == 7'(j));

        asb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_wr_en      (wr_sel[j]),
            .i_wr_entry   (wr_entry),
            .i_next_entry (cell_d[j]),
            .o_entry      (cell_q[j])
        );
    end

    // The top bits of the head's phase pick the quadrant and the table
    // entry; odd quadrants read the table backwards, the second half is
    // negative.
    assign tab_idx  = cell_q[0].phase[31 -: SINE_TABLE_BITS];
    assign quad     = tab_idx[SINE_TABLE_BITS-1 -: 2];
    assign rom_addr = quad[0] ? (AW'(QN) - {1'b0, tab_idx[SINE_TABLE_BITS-3:0]})
                              : {1'b0, tab_idx[SINE_TABLE_BITS-3:0]};

    always_ff @(posedge i_clk) begin
        r_sine <= QTAB[rom_addr];
        r_n1   <= quad[1];
        r_w1   <= cell_q[0].weight;
        r_prod <= prod_full[30:0];
        r_n2   <= r_n1;
        r_w2   <= r_w1;
    end

    // Weight times sine magnitude stays below 2^31.
    assign prod_full = {17'b0, r_w1} * {16'b0, r_sine};
    assign prod_ext  = $signed({{(ACC_W - 31){1'b0}}, r_prod});

    // Normalisation, clipping and the output register.
    asb_div #(
        .OSCILLATORS (OSCILLATORS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_acc    (r_acc),
        .i_wsum   (r_wsum),
        .i_last   (r_left == LEFT_W'(1)),
        .o_idle   (div_idle),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_sample (o_sample),
        .o_last   (o_last)
    );

    // A sample leaves for the divider only with the pipeline empty.
    a_handoff_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (!r_v1 && !r_v2))
        else $error("sample handed to the divider before the pipeline drained");

    // Pipeline work only exists while a sample is being evaluated.
    a_pipe_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state == S_ROT || r_state == S_DRAIN))
        else $error("evaluation pipeline active outside a burst");

    // Each sample handed on advances the time base by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_count == $past(r_count) + 32'd1))
        else $error("sample counter did not advance by one");

endmodule

// ===== bench/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import asb_pkg::*;

    // Bank geometry as the block is built by default.
    localparam int OSC_COUNT  = ASB_OSCILLATORS;
    localparam int TAB_BITS   = ASB_SINE_TABLE_BITS;
    localparam int BURST_CAP  = ASB_MAX_BURST;
    localparam int QUARTER_SZ = 1 << (TAB_BITS - 2);

    // The fourth command code has no meaning and must be ignored by the block.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Number of random commands, not counting the ignored spare code.
    localparam int RANDOM_CMDS = 230;

    // The watchdog limit leaves a wide margin over the longest stretch without a transfer in a
    // correct run, which is set by the wait for the first sample of a burst, the spacing of
    // later samples and the longest receiver pause.
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_MAX   = 10;

    // One command as presented on the input channel.
    typedef struct {
        logic [1:0]  command;
        logic [3:0]  osc_index;
        logic [15:0] weight;
        logic [15:0] phase_offset;
        logic [31:0] freq_step;
        logic [6:0]  burst_len;
    } bank_cmd_t;

    // One audio sample as it should leave the output channel.
    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } audio_out_t;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [1:0]         i_command      = '0;
    logic [3:0]         i_osc_index    = '0;
    logic [15:0]        i_weight       = '0;
    logic [15:0]        i_phase_offset = '0;
    logic [31:0]        i_freq_step    = '0;
    logic [6:0]         i_burst_len    = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic signed [15:0] o_sample;
    logic               o_last;

    additive_sine_bank_synth_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_osc_index    (i_osc_index),
        .i_weight       (i_weight),
        .i_phase_offset (i_phase_offset),
        .i_freq_step    (i_freq_step),
        .i_burst_len    (i_burst_len),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .o_last         (o_last)
    );

    // Commands still to be driven, and the samples the bank model says must follow.
    bank_cmd_t  cmd_backlog[$];
    audio_out_t pending_samples[$];

    // Private copy of the oscillator bank and the time base.
    logic [15:0] osc_weight[OSC_COUNT] = '{default: '0};
    logic [15:0] osc_offset[OSC_COUNT] = '{default: '0};
    logic [31:0] osc_step[OSC_COUNT]   = '{default: '0};
    logic [31:0] sample_base           = '0;
    int          quarter_wave[QUARTER_SZ + 1];

    int   fault_count = 0;
    int   idle_run    = 0;
    int   tx_gap      = 0;
    int   rx_pause    = 0;
    int   calm_left   = 0;
    logic cmd_taken   = 1'b0;
    logic tx_next;
    bank_cmd_t  tx_cmd;
    bank_cmd_t  rx_cmd;
    audio_out_t want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bank model
    // ------------------------------------------------------------------

    // Quarter wave of the sine table at the scale 1.0 = 32768. The angle is taken in
    // Q30 and the Taylor series runs to the thirteenth power, each term being derived
    // from the previous one and truncated at every step, exactly as the hardware table.
    function automatic void build_quarter_wave();
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] partial;
        int                 k;
        int                 m;
        for (k = 0; k <= QUARTER_SZ; k++) begin
            x       = (64'(k) * ASB_HALF_PI_Q30) >> (TAB_BITS - 2);
            term    = x;
            partial = $signed(x);
            for (m = 1; m <= 6; m++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * m) * (2 * m + 1));
                if (m % 2 == 1) begin
                    partial = partial - $signed(term);
                end else begin
                    partial = partial + $signed(term);
                end
            end
            if (partial < 0) begin
                partial = 0;
            end
            if (partial > 64'sd1073741824) begin
                partial = 64'sd1073741824;
            end
            quarter_wave[k] = int'((64'(partial) + 64'd16384) >> 15);
        end
    endfunction

    // Full-turn table entry, folded from the quarter wave by symmetry.
    function automatic int sine_lookup(input int unsigned idx);
        int unsigned quad;
        int unsigned k;
        int          v;
        quad = (idx >> (TAB_BITS - 2)) & 3;
        k    = idx & (QUARTER_SZ - 1);
        v    = (quad == 0 || quad == 2) ? quarter_wave[k] : quarter_wave[QUARTER_SZ - k];
        return (quad >= 2) ? -v : v;
    endfunction

    // Weighted mix of all oscillators at sample n, normalised by the weight sum,
    // truncated towards zero and clipped to the output full scale.
    function automatic logic [15:0] mix_sample(input logic [31:0] n);
        logic signed [63:0] acc;
        logic [63:0]        wsum;
        logic [63:0]        mag;
        logic [63:0]        quot;
        logic [31:0]        phase;
        logic               neg;
        int                 j;
        acc  = 0;
        wsum = 0;
        for (j = 0; j < OSC_COUNT; j++) begin
            phase = osc_step[j] * n + {osc_offset[j], 16'h0000};
            acc   = acc + $signed({48'd0, osc_weight[j]})
                        * 64'(sine_lookup(phase >> (32 - TAB_BITS)));
            wsum  = wsum + osc_weight[j];
        end
        if (wsum == 0) begin
            return '0;
        end
        neg  = acc < 0;
        mag  = neg ? 64'(-acc) : 64'(acc);
        quot = (mag * ASB_OUT_SCALE) / (wsum * 64'd32768);
        if (quot > ASB_OUT_SCALE) begin
            quot = ASB_OUT_SCALE;
        end
        return neg ? 16'(64'd0 - quot) : quot[15:0];
    endfunction

    // Applies one transferred command to the model and queues the samples it causes.
    function automatic void run_bank_command(input bank_cmd_t c);
        int unsigned count;
        int unsigned i;
        case (c.command)
            CMD_WRITE: begin
                if (c.osc_index < OSC_COUNT) begin
                    osc_weight[c.osc_index] = c.weight;
                    osc_offset[c.osc_index] = c.phase_offset;
                    osc_step[c.osc_index]   = c.freq_step;
                end
            end
            CMD_CLEAR: begin
                sample_base = '0;
            end
            CMD_BURST: begin
                count = (c.burst_len > BURST_CAP) ? BURST_CAP : c.burst_len;
                for (i = 0; i < count; i++) begin
                    pending_samples.push_back('{mix_sample(sample_base + i), i + 1 == count});
                end
                sample_base = sample_base + count;
            end
            default: begin
                // The spare code leaves the bank untouched.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic bank_cmd_t bank_cmd(input logic [1:0] command, input logic [3:0] idx,
                                           input logic [15:0] weight, input logic [15:0] offset,
                                           input logic [31:0] step, input logic [6:0] len);
        return '{command, idx, weight, offset, step, len};
    endfunction

    // Idle length for either side: mostly none or short, now and then long, and
    // nothing at all during a calm stretch so that back-to-back traffic also occurs.
    function automatic int pick_gap();
        int r;
        if (calm_left != 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    initial begin : fill_backlog
        bank_cmd_t c;
        int        counted;
        int        r;
        build_quarter_wave();

        // An empty bank has a zero weight sum and must give silence.
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd1));
        // Full weight at zero phase: sine of zero.
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd0, 16'hFFFF, 16'h0000, 32'd0, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd2));
        // A quarter turn and three quarters give positive and negative full scale.
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd0, 16'hFFFF, 16'h4000, 32'd0, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd1));
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd0, 16'hFFFF, 16'hC000, 32'd0, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd1));
        // Last entry with extreme offset and step, and a half-turn oscillator.
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd15, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd7, 16'h8000, 16'h2000, 32'h8000_0000,
                                       7'd0));
        // Longest burst, then a length beyond the cap which saturates, then a zero length.
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd64));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd127));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd0));
        // The spare code with every field set must change nothing.
        cmd_backlog.push_back(bank_cmd(CMD_SPARE, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                       7'h7F));
        cmd_backlog.push_back(bank_cmd(CMD_CLEAR, 4'd0, 16'd0, 16'd0, 32'd0, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd3));
        // Silencing an entry with a zero weight, then a slow oscillator elsewhere.
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd0, 16'd0, 16'd0, 32'd0, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_WRITE, 4'd3, 16'd12345, 16'h1234, 32'h0100_0000,
                                       7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd65));
        cmd_backlog.push_back(bank_cmd(CMD_CLEAR, 4'd0, 16'd0, 16'd0, 32'd0, 7'd0));
        cmd_backlog.push_back(bank_cmd(CMD_BURST, 4'd0, 16'd0, 16'd0, 32'd0, 7'd5));

        // Random part: mostly entry writes followed by bursts, with the odd time base
        // reset and spare code. Every field is randomised whatever the command, so that
        // each input bit toggles; only the fields that matter get a shaped distribution.
        counted = 0;
        while (counted < RANDOM_CMDS) begin
            c.osc_index    = 4'($urandom_range(0, 15));
            c.weight       = 16'($urandom);
            c.phase_offset = 16'($urandom);
            c.freq_step    = $urandom;
            c.burst_len    = 7'($urandom);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                c.command = CMD_WRITE;
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    c.weight = 16'd0;
                end else if (r == 1) begin
                    c.weight = 16'hFFFF;
                end else if (r < 5) begin
                    c.weight = 16'($urandom_range(1, 255));
                end
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    c.freq_step = 32'd0;
                end else if (r == 1) begin
                    c.freq_step = 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
                end else if (r < 5) begin
                    c.freq_step = 32'($urandom_range(0, 1 << 24));
                end
            end else if (r < 82) begin
                c.command = CMD_BURST;
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    c.burst_len = 7'd0;
                end else if (r < 72) begin
                    c.burst_len = 7'($urandom_range(1, 8));
                end else if (r < 93) begin
                    c.burst_len = 7'($urandom_range(9, 64));
                end else begin
                    c.burst_len = 7'($urandom_range(65, 127));
                end
            end else if (r < 92) begin
                c.command = CMD_CLEAR;
            end else begin
                c.command = CMD_SPARE;
            end
            cmd_backlog.push_back(c);
            if (c.command != CMD_SPARE) begin
                counted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver, both acting on the falling edge
    // ------------------------------------------------------------------

    // Once a transfer has been seen on the rising edge, the next command (if any, and
    // once its gap has run out) is presented here. Valid is worked out in a variable
    // first so that it gets one assignment only, even when it stays high.
    always @(negedge i_clk) begin
        tx_next = i_valid;
        if (cmd_taken) begin
            cmd_taken = 1'b0;
            tx_next   = 1'b0;
            tx_gap    = pick_gap();
        end
        if (!tx_next && i_rst_n) begin
            if (tx_gap != 0) begin
                tx_gap--;
            end else if (cmd_backlog.size() != 0) begin
                tx_cmd          = cmd_backlog.pop_front();
                i_command      <= tx_cmd.command;
                i_osc_index    <= tx_cmd.osc_index;
                i_weight       <= tx_cmd.weight;
                i_phase_offset <= tx_cmd.phase_offset;
                i_freq_step    <= tx_cmd.freq_step;
                i_burst_len    <= tx_cmd.burst_len;
                tx_next         = 1'b1;
            end
        end
        i_valid <= tx_next;
    end

    // The receiver stalls now and then; calm stretches switch all idling off for a while.
    always @(negedge i_clk) begin
        if (calm_left != 0) begin
            calm_left--;
        end else if ($urandom_range(0, 249) == 0) begin
            calm_left = $urandom_range(40, 160);
        end
        if (rx_pause != 0) begin
            rx_pause--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                rx_pause = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checking, on the rising edge
    // ------------------------------------------------------------------

    task automatic note_failure(input string text);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, text);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // A command transfer updates the model and queues the samples it causes.
            if (i_valid && o_ready) begin
                rx_cmd.command      = i_command;
                rx_cmd.osc_index    = i_osc_index;
                rx_cmd.weight       = i_weight;
                rx_cmd.phase_offset = i_phase_offset;
                rx_cmd.freq_step    = i_freq_step;
                rx_cmd.burst_len    = i_burst_len;
                run_bank_command(rx_cmd);
                cmd_taken = 1'b1;
            end
            // A sample transfer is compared with the oldest expected sample.
            if (o_valid && i_ready) begin
                if (pending_samples.size() == 0) begin
                    note_failure($sformatf("unexpected sample %0d, last %0b", o_sample,
                                           o_last));
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample !== want.sample || o_last !== want.last) begin
                        note_failure($sformatf("sample expected %0d got %0d, last expected %0b got %0b",
                                               want.sample, o_sample, want.last, o_last));
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel has transferred for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
            if (idle_run >= IDLE_LIMIT) begin
                $display("FAIL additive_sine_bank_synth_unit");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset and end of run
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Wait for every command to be transferred, then for every expected sample.
        while (cmd_backlog.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        // Give the block time to show any surplus sample.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_samples.size() == 0) begin
            $display("PASS additive_sine_bank_synth_unit");
        end else begin
            $display("FAIL additive_sine_bank_synth_unit");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/asb_pkg.sv
src/asb_cell.sv
src/asb_div.sv
src/additive_sine_bank_synth_unit.sv
bench/testbench.sv
